// File: rtl/dms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounced move sequencer package
// Shared item types, register indexes, state and configuration records.
// ----------------------------------------------------------------------------
package dms_pkg;

	localparam int unsigned MAX_PENDING_DEFAULT = 255;
	localparam int unsigned CFG_INDEX_W         = 3;
	localparam int unsigned CFG_DATA_W          = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_GAP_TICKS    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MOVES_PER_REQUEST = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_DISTANCE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ARRIVE_TOLERANCE  = 3'd4;

	// Register reset values.
	localparam logic [15:0]        DEBOUNCE_TICKS_RST    = 16'd50;
	localparam logic [15:0]        MOVE_GAP_TICKS_RST    = 16'd500;
	localparam logic [3:0]         MOVES_PER_REQUEST_RST = 4'd3;
	localparam logic signed [31:0] STEP_DISTANCE_RST     = 32'sd153600;
	localparam logic [15:0]        ARRIVE_TOLERANCE_RST  = 16'd10;

	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	typedef struct packed {
		logic              button_level;
		logic signed [31:0] actual_position;
	} in_item_t;

	typedef struct packed {
		logic               issue_target;
		logic signed [31:0] target_position;
		logic               arrived;
		logic               sequence_done;
		logic               busy_res;
		logic [3:0]         move_number;
		logic [7:0]         pending_requests;
		logic               toggle_seen;
		logic               stable_level;
	} out_item_t;

	typedef struct packed {
		logic [15:0]        debounce_ticks;
		logic [15:0]        move_gap_ticks;
		logic [3:0]         moves_per_request;
		logic signed [31:0] step_distance;
		logic [15:0]        arrive_tolerance;
	} cfg_t;

	typedef struct packed {
		logic               previous_raw;
		logic               accepted_level;
		logic [15:0]        ticks_since_change;
		logic [7:0]         request_count;
		logic               run_active;
		logic [3:0]         moves_done;
		logic               target_active;
		logic signed [31:0] target_value;
		logic [15:0]        ticks_since_move;
	} state_t;

endpackage

// File: rtl/debounced_move_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounced move sequencer core
// Debounces a button, queues move requests and sequences relative moves.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is one time tick: the raw button level and the motor's
// actual position. For every accepted item exactly one result item is
// produced, carrying target issue and arrival flags, the current target,
// run status, the pending request count and the debounced level.
// An item is accepted when in_valid is high and in_stall is low; a result
// is taken when out_valid is high and out_stall is low.
// The result of an item is in the output register on the cycle after
// acceptance. Throughput is one item per cycle when not stalled, set
// by the combinational update between state registers and the output
// register. in_stall rises only while a finished result is held and the
// receiver stalls; the held result and all state stay unchanged meanwhile.
// Reset clears the debouncer, queue and sequencer state (button released,
// nothing pending, no run) and loads the register reset values; the block
// takes items on the first cycle after reset. Configuration writes take
// effect on the next edge and are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module debounced_move_sequencer_core #(
	parameter int unsigned MAX_PENDING = dms_pkg::MAX_PENDING_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  dms_pkg::in_item_t                    in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output dms_pkg::out_item_t                   out_item,
	input  logic                                 cfg_write,
	input  logic [dms_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dms_pkg::CFG_DATA_W-1:0]       cfg_data
);

	dms_pkg::cfg_t      cfg_q;
	dms_pkg::state_t    state_q;
	dms_pkg::state_t    state_nxt;
	dms_pkg::out_item_t res;
	dms_pkg::out_item_t out_item_q;
	logic               out_valid_q;
	logic               accept;

	// The input side only waits when the output register is full and stalled.
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= dms_pkg::DEBOUNCE_TICKS_RST;
			cfg_q.move_gap_ticks    <= dms_pkg::MOVE_GAP_TICKS_RST;
			cfg_q.moves_per_request <= dms_pkg::MOVES_PER_REQUEST_RST;
			cfg_q.step_distance     <= dms_pkg::STEP_DISTANCE_RST;
			cfg_q.arrive_tolerance  <= dms_pkg::ARRIVE_TOLERANCE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				dms_pkg::CFG_DEBOUNCE_TICKS:    cfg_q.debounce_ticks    <= cfg_data[15:0];
				dms_pkg::CFG_MOVE_GAP_TICKS:    cfg_q.move_gap_ticks    <= cfg_data[15:0];
				dms_pkg::CFG_MOVES_PER_REQUEST: cfg_q.moves_per_request <= cfg_data[3:0];
				dms_pkg::CFG_STEP_DISTANCE:     cfg_q.step_distance     <= cfg_data[31:0];
				dms_pkg::CFG_ARRIVE_TOLERANCE:  cfg_q.arrive_tolerance  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	dms_step #(
		.MAX_PENDING(MAX_PENDING)
	) u_step (
		.cur (state_q),
		.cfg (cfg_q),
		.item(in_item),
		.nxt (state_nxt),
		.res (res)
	);

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.previous_raw       <= 1'b1;
			state_q.accepted_level     <= 1'b1;
			state_q.ticks_since_change <= '0;
			state_q.request_count      <= '0;
			state_q.run_active         <= 1'b0;
			state_q.moves_done         <= '0;
			state_q.target_active      <= 1'b0;
			state_q.target_value       <= '0;
			state_q.ticks_since_move   <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q <= res;
		end
	end

	// A new target is only ever issued inside a run.
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.issue_target |-> out_item.busy_res)
		else $error("target issued outside a move run");

	// A finished run neither stays busy nor issues a target on the same tick.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.sequence_done |-> !out_item.busy_res && !out_item.issue_target)
		else $error("run finished while still busy or issuing");

	// Every accepted tick leaves a result in the output register.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted tick produced no result");

	// An arrival and a new target never share a tick.
	a_arrive_issue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.arrived && out_item.issue_target))
		else $error("arrival and target issue on the same tick");

endmodule

// File: rtl/dms_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounced move sequencer tick update
// Computes the next state and the result item of one tick.
// ----------------------------------------------------------------------------
module dms_step #(
	parameter int unsigned MAX_PENDING = dms_pkg::MAX_PENDING_DEFAULT
) (
	input  dms_pkg::state_t    cur,
	input  dms_pkg::cfg_t      cfg,
	input  dms_pkg::in_item_t  item,
	output dms_pkg::state_t    nxt,
	output dms_pkg::out_item_t res
);

	localparam int unsigned QUEUE_CAP_I = (MAX_PENDING < 255) ? MAX_PENDING : 255;
	localparam logic [7:0]  QUEUE_CAP   = 8'(QUEUE_CAP_I);

	logic        raw_changed;
	logic [15:0] tsc;
	logic        level_accept;
	logic [15:0] tsm;
	logic [31:0] pos_err;
	logic [31:0] err_mag;
	logic        in_tolerance;

	assign raw_changed = item.button_level != cur.previous_raw;
	assign tsc = raw_changed ? 16'd0 :
		((cur.ticks_since_change == dms_pkg::TICK_MAX) ? dms_pkg::TICK_MAX :
		cur.ticks_since_change + 16'd1);
	assign level_accept = (tsc > cfg.debounce_ticks) &&
		(item.button_level != cur.accepted_level);
	assign tsm = (cur.ticks_since_move == dms_pkg::TICK_MAX) ? dms_pkg::TICK_MAX :
		cur.ticks_since_move + 16'd1;

	// Position error modulo 2^32; the most negative value keeps magnitude 2^31.
	assign pos_err      = item.actual_position - cur.target_value;
	assign err_mag      = pos_err[31] ? (32'd0 - pos_err) : pos_err;
	assign in_tolerance = err_mag < {16'd0, cfg.arrive_tolerance};

	always_comb begin
		nxt = cur;
		res = '0;

		nxt.previous_raw       = item.button_level;
		nxt.ticks_since_change = tsc;
		nxt.ticks_since_move   = tsm;
		if (level_accept) begin
			nxt.accepted_level = item.button_level;
			res.toggle_seen    = 1'b1;
			if (cur.request_count < QUEUE_CAP) begin
				nxt.request_count = cur.request_count + 8'd1;
			end
		end

		if (!cur.run_active && (nxt.request_count != 8'd0)) begin
			nxt.moves_done    = 4'd0;
			nxt.run_active    = 1'b1;
			nxt.target_active = 1'b0;
			nxt.request_count = nxt.request_count - 8'd1;
		end

		if (nxt.run_active) begin
			if (nxt.moves_done < cfg.moves_per_request) begin
				if (!nxt.target_active) begin
					if (tsm >= cfg.move_gap_ticks) begin
						nxt.target_value  = item.actual_position + cfg.step_distance;
						nxt.target_active = 1'b1;
						res.issue_target  = 1'b1;
					end
				end else if (in_tolerance) begin
					res.arrived          = 1'b1;
					nxt.moves_done       = nxt.moves_done + 4'd1;
					nxt.target_active    = 1'b0;
					nxt.ticks_since_move = 16'd0;
				end
			end else begin
				nxt.run_active    = 1'b0;
				res.sequence_done = 1'b1;
			end
		end

		// On an arrival the target is still shown although it is retired.
		res.target_position = (nxt.target_active || res.arrived) ? nxt.target_value : '0;
		res.busy_res         = nxt.run_active;
		res.move_number      = nxt.moves_done;
		res.pending_requests = nxt.request_count;
		res.stable_level     = nxt.accepted_level;
	end

endmodule

// File: tb/sv/debounced_move_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounced move sequencer core testbench
// Sends button and position ticks through the valid/stall handshake. A
// behavioral model of the debouncer, request queue and move sequencer
// predicts one result item per tick, and each result is checked field by
// field. A short directed table comes first: idle ticks after reset, target
// arrival at the tolerance edge, a zero target, position wrap, the most
// negative error, runs of zero moves and the longest debounce. Random
// phases follow: mixed settings, a stuck run that fills the request queue,
// a drain of that queue and the far limits of the registers. Both sides idle
// in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module debounced_move_sequencer_core_tb;

	typedef enum logic [1:0] {
		ROW_SETTINGS,
		ROW_TICK,
		ROW_TICK_IDLE
	} row_kind_t;

	typedef enum logic [1:0] {
		PH_MIXED,
		PH_FILL_QUEUE,
		PH_DRAIN_QUEUE,
		PH_FAR_LIMITS
	} phase_kind_t;

	typedef struct {
		row_kind_t         kind;
		dms_pkg::cfg_t     settings;
		dms_pkg::in_item_t tick;
	} dir_row_t;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam logic [7:0]  QUEUE_LIMIT = (dms_pkg::MAX_PENDING_DEFAULT < 255) ?
		8'(dms_pkg::MAX_PENDING_DEFAULT) : 8'd255;

	// Result of a tick while no run is going and the button rests released.
	localparam dms_pkg::out_item_t IDLE_RELEASED = '{stable_level: 1'b1, default: '0};

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	dms_pkg::in_item_t               in_item   = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	dms_pkg::out_item_t              out_item;
	logic                            cfg_write = 1'b0;
	logic [dms_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [dms_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	// Model state of the block, named for what it tracks.
	dms_pkg::cfg_t      cfg_shadow = '{dms_pkg::DEBOUNCE_TICKS_RST,
		dms_pkg::MOVE_GAP_TICKS_RST, dms_pkg::MOVES_PER_REQUEST_RST,
		dms_pkg::STEP_DISTANCE_RST, dms_pkg::ARRIVE_TOLERANCE_RST};
	logic               prev_raw    = 1'b1;
	logic               stable_lvl  = 1'b1;
	logic [15:0]        quiet_ticks = '0;
	logic [7:0]         queued      = '0;
	logic               run_on      = 1'b0;
	logic [3:0]         moves_made  = '0;
	logic               target_live = 1'b0;
	logic signed [31:0] target_pos  = '0;
	logic [15:0]        gap_ticks   = '0;

	dms_pkg::out_item_t predicted_reports [$];
	dir_row_t           directed_rows [$];
	int unsigned        mismatch_count = 0;
	int unsigned        cycle_count    = 0;
	int unsigned        stall_left     = 0;
	logic               idle_on        = 1'b1;
	logic               drive_level    = 1'b1;
	int                 hold_left      = 0;

	debounced_move_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Advances the model by one tick and returns the result it produces.
	function automatic dms_pkg::out_item_t step_sequencer(input dms_pkg::in_item_t tick);
		dms_pkg::out_item_t r;
		logic [31:0]        err;
		r = '0;
		if (tick.button_level != prev_raw)
			quiet_ticks = '0;
		else if (quiet_ticks != dms_pkg::TICK_MAX)
			quiet_ticks++;
		if (quiet_ticks > cfg_shadow.debounce_ticks && tick.button_level != stable_lvl) begin
			stable_lvl    = tick.button_level;
			r.toggle_seen = 1'b1;
			if (queued < QUEUE_LIMIT)
				queued++;
		end
		prev_raw = tick.button_level;
		if (gap_ticks != dms_pkg::TICK_MAX)
			gap_ticks++;

		if (!run_on && queued != 0) begin
			moves_made  = '0;
			run_on      = 1'b1;
			target_live = 1'b0;
			queued--;
		end
		if (run_on) begin
			if (moves_made < cfg_shadow.moves_per_request) begin
				if (!target_live) begin
					if (gap_ticks >= cfg_shadow.move_gap_ticks) begin
						target_pos     = tick.actual_position + cfg_shadow.step_distance;
						target_live    = 1'b1;
						r.issue_target = 1'b1;
					end
				end else begin
					// Error is taken modulo 2^32; the most negative value keeps
					// magnitude 2^31 after negation.
					err = tick.actual_position - target_pos;
					if (err[31])
						err = -err;
					if (err < {16'd0, cfg_shadow.arrive_tolerance}) begin
						r.arrived         = 1'b1;
						r.target_position = target_pos;
						moves_made++;
						target_live = 1'b0;
						gap_ticks   = '0;
					end
				end
			end else begin
				run_on          = 1'b0;
				r.sequence_done = 1'b1;
			end
		end
		if (target_live)
			r.target_position = target_pos;
		r.busy_res         = run_on;
		r.move_number      = moves_made;
		r.pending_requests = queued;
		r.stable_level     = stable_lvl;
		return r;
	endfunction

	// Random tick: button held long enough to pass the debouncer most of the
	// time, with short bounces in between; position mostly near a live target.
	function automatic dms_pkg::in_item_t random_tick(input phase_kind_t kind);
		dms_pkg::in_item_t tick;
		int                reach;
		if (kind != PH_DRAIN_QUEUE) begin
			if (hold_left == 0) begin
				drive_level = ~drive_level;
				if (kind == PH_FILL_QUEUE)
					hold_left = 2;
				else if ($urandom_range(0, 3) == 0)
					hold_left = $urandom_range(1, 3);
				else
					hold_left = cfg_shadow.debounce_ticks + $urandom_range(1, 4);
			end
			hold_left--;
		end
		tick.button_level = drive_level;
		if (target_live && $urandom_range(0, 9) < 7) begin
			reach = ((cfg_shadow.arrive_tolerance > 1000) ? 1000 :
				int'(cfg_shadow.arrive_tolerance)) + 2;
			tick.actual_position = target_pos + (int'($urandom_range(0, 2 * reach)) - reach);
		end else begin
			tick.actual_position = $urandom;
		end
		return tick;
	endfunction

	function automatic dms_pkg::cfg_t make_settings(input logic [15:0] debounce,
		input logic [15:0] gap, input logic [3:0] moves, input logic [31:0] step,
		input logic [15:0] tol);
		dms_pkg::cfg_t s;
		s.debounce_ticks    = debounce;
		s.move_gap_ticks    = gap;
		s.moves_per_request = moves;
		s.step_distance     = step;
		s.arrive_tolerance  = tol;
		return s;
	endfunction

	function automatic dir_row_t tick_row(input row_kind_t kind, input logic level,
		input logic [31:0] pos);
		dir_row_t row;
		row.kind                 = kind;
		row.settings             = '0;
		row.tick.button_level    = level;
		row.tick.actual_position = pos;
		return row;
	endfunction

	function automatic dir_row_t settings_row(input dms_pkg::cfg_t s);
		dir_row_t row;
		row.kind     = ROW_SETTINGS;
		row.settings = s;
		row.tick     = '0;
		return row;
	endfunction

	// Offers one tick and holds it until accepted. Known idle ticks are checked
	// against the fixed idle result, all others against the model.
	task automatic send_tick(input dms_pkg::in_item_t tick, input bit idle_known);
		dms_pkg::out_item_t predicted;
		in_valid <= 1'b1;
		in_item  <= tick;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = step_sequencer(tick);
		predicted_reports.push_back(idle_known ? IDLE_RELEASED : predicted);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16))
				@(posedge clk);
		end
	endtask

	task automatic write_one(input logic [dms_pkg::CFG_INDEX_W-1:0] idx,
		input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Register writes happen only with no item in flight; the task waits until
	// every predicted result has been taken before writing.
	task automatic load_settings(input dms_pkg::cfg_t s);
		in_valid <= 1'b0;
		while (predicted_reports.size() != 0)
			@(posedge clk);
		repeat (2)
			@(posedge clk);
		write_one(dms_pkg::CFG_DEBOUNCE_TICKS, {16'd0, s.debounce_ticks});
		write_one(dms_pkg::CFG_MOVE_GAP_TICKS, {16'd0, s.move_gap_ticks});
		write_one(dms_pkg::CFG_MOVES_PER_REQUEST, {28'd0, s.moves_per_request});
		write_one(dms_pkg::CFG_STEP_DISTANCE, s.step_distance);
		write_one(dms_pkg::CFG_ARRIVE_TOLERANCE, {16'd0, s.arrive_tolerance});
		cfg_write  <= 1'b0;
		cfg_shadow = s;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: check every taken item, then decide the next stall.
	always @(posedge clk) begin
		dms_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_reports.size() == 0) begin
				$error("result item arrived with nothing expected");
				mismatch_count++;
			end else begin
				want = predicted_reports.pop_front();
				compare_field("issue_target", 32'(want.issue_target),
					32'(out_item.issue_target));
				compare_field("target_position", want.target_position,
					out_item.target_position);
				compare_field("arrived", 32'(want.arrived), 32'(out_item.arrived));
				compare_field("sequence_done", 32'(want.sequence_done),
					32'(out_item.sequence_done));
				compare_field("busy_res", 32'(want.busy_res), 32'(out_item.busy_res));
				compare_field("move_number", 32'(want.move_number),
					32'(out_item.move_number));
				compare_field("pending_requests", 32'(want.pending_requests),
					32'(out_item.pending_requests));
				compare_field("toggle_seen", 32'(want.toggle_seen),
					32'(out_item.toggle_seen));
				compare_field("stable_level", 32'(want.stable_level),
					32'(out_item.stable_level));
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 15);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		phase_kind_t   plan [8];
		dir_row_t      row;
		dms_pkg::cfg_t pick;
		int unsigned   tick_total;

		plan = '{PH_MIXED, PH_MIXED, PH_FILL_QUEUE, PH_DRAIN_QUEUE, PH_FAR_LIMITS,
			PH_MIXED, PH_MIXED, PH_MIXED};

		// Reset settings: position extremes and a short glitch, nothing moves.
		directed_rows.push_back(tick_row(ROW_TICK_IDLE, 1'b1, 32'h0000_0000));
		directed_rows.push_back(tick_row(ROW_TICK_IDLE, 1'b1, 32'h7FFF_FFFF));
		directed_rows.push_back(tick_row(ROW_TICK_IDLE, 1'b1, 32'h8000_0000));
		directed_rows.push_back(tick_row(ROW_TICK_IDLE, 1'b0, 32'hFFFF_FFFF));
		directed_rows.push_back(tick_row(ROW_TICK_IDLE, 1'b1, 32'h0000_0000));
		// No debounce, no gap: press, two moves, arrival just outside and
		// just inside the tolerance, then a target that lands on zero.
		directed_rows.push_back(settings_row(make_settings(16'd0, 16'd0, 4'd2, 32'd100, 16'd5)));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd0));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd0));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd95));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd96));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, -32'sd100));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd0));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd5));
		// Most negative step: error of exactly 2^31, then arrival across wrap.
		directed_rows.push_back(settings_row(make_settings(16'd0, 16'd0, 4'd2,
			32'h8000_0000, 16'hFFFF)));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b1, 32'd0));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b1, 32'd0));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b1, 32'd0));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b1, 32'h7FFF_FFFF));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b1, 32'h7FFF_FFF0));
		// Zero moves: the running run ends, the next starts and ends at once.
		directed_rows.push_back(settings_row(make_settings(16'd0, 16'd0, 4'd0,
			32'h8000_0000, 16'hFFFF)));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd0));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd0));
		// Longest debounce: no level is accepted.
		directed_rows.push_back(settings_row(make_settings(16'hFFFF, 16'd0, 4'd3,
			32'd153600, 16'd10)));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b1, 32'd1));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b1, 32'd2));
		directed_rows.push_back(tick_row(ROW_TICK, 1'b0, 32'd3));

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_SETTINGS:  load_settings(row.settings);
				ROW_TICK:      send_tick(row.tick, 1'b0);
				ROW_TICK_IDLE: send_tick(row.tick, 1'b1);
				default:       ;
			endcase
		end

		foreach (plan[p]) begin
			if (p == $size(plan) - 1)
				idle_on <= 1'b0;
			case (plan[p])
				PH_FILL_QUEUE: begin
					// Tolerance zero never arrives, so the run sticks and every
					// second tick queues a request until the queue is full.
					pick       = make_settings(16'd0, 16'd0, 4'd15, $urandom, 16'd0);
					tick_total = 560;
				end
				PH_DRAIN_QUEUE: begin
					pick       = make_settings(16'd0, 16'd0, 4'd0, $urandom, 16'd0);
					tick_total = 300;
				end
				PH_FAR_LIMITS: begin
					pick       = make_settings(16'd0, 16'hFFFF, 4'd15, 32'h7FFF_FFFF, 16'hFFFF);
					tick_total = 60;
				end
				default: begin
					pick.debounce_ticks = ($urandom_range(0, 3) == 0) ?
						16'($urandom_range(7, 20)) : 16'($urandom_range(0, 6));
					pick.move_gap_ticks = ($urandom_range(0, 2) == 0) ?
						16'd0 : 16'($urandom_range(1, 12));
					pick.moves_per_request = 4'($urandom_range(0, 15));
					pick.step_distance = ($urandom_range(0, 2) == 0) ?
						$urandom : 32'($urandom_range(0, 4000)) - 32'd2000;
					case ($urandom_range(0, 5))
						0:       pick.arrive_tolerance = 16'd0;
						1:       pick.arrive_tolerance = 16'd1;
						5:       pick.arrive_tolerance = 16'hFFFF;
						default: pick.arrive_tolerance = 16'($urandom_range(2, 40));
					endcase
					tick_total = 130;
				end
			endcase
			load_settings(pick);
			hold_left = 0;
			repeat (tick_total)
				send_tick(random_tick(plan[p]), 1'b0);
		end

		in_valid <= 1'b0;
		while (predicted_reports.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
